// ===== hdl/strs_pkg.sv =====
package strs_pkg;

    localparam int DELTA_W        = 17;
    localparam int THR_W          = 16;
    localparam int QUO_W          = 16;
    localparam int CNT_W          = $clog2(QUO_W);
    localparam int HIST_DEPTH_DEF = 8;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2048);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic need_div;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/strs_ctrl.sv =====
module strs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  strs_pkg::t_stat i_stat,
    output strs_pkg::t_cmd  o_cmd
);
    import strs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                priority if (i_stat.skip) begin
                    n_state = S_DONE;
                end else if (!i_stat.need_div) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_DIV:  o_cmd.div_step = !i_stat.skip && i_stat.need_div;
            S_MUL:  o_cmd.mul = 1'b1;
            S_ACC:  o_cmd.acc = 1'b1;
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== hdl/strs_dp.sv =====
module strs_dp #(
    parameter int HISTORY_DEPTH = strs_pkg::HIST_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [strs_pkg::DELTA_W-1:0]   i_delta_angle,
    input  logic                                  i_clear_history,
    input  logic                                  i_cfg_valid,
    input  logic        [strs_pkg::THR_W-1:0]     i_cfg_top_threshold,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [strs_pkg::DELTA_W-1:0]   o_smoothed_delta,
    input  strs_pkg::t_cmd                        i_cmd,
    output strs_pkg::t_stat                       o_stat
);
    import strs_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int LOG_D = $clog2(HISTORY_DEPTH + 1) - 1;
    localparam int SUM_W = DELTA_W + $clog2(HISTORY_DEPTH);
    localparam int RES_W = SUM_W + 1;
    localparam int PROD_W = 2 * DELTA_W + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
    localparam logic signed [RES_W-1:0] OUT_MIN = -(RES_W'(65536));
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(65535);

    // ring memory and per-entry valid bits
    logic signed [DELTA_W-1:0] r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]  r_valid;
    logic signed [DELTA_W-1:0] r_old;

    logic [THR_W-1:0]          r_thr;
    logic [AW-1:0]             r_ptr;
    logic [AW-1:0]             r_nptr;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_need;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;

    logic signed [DELTA_W-1:0] r_v;
    logic                      r_clr;
    logic                      r_byp;
    logic [THR_W-1:0]          r_den;
    logic [THR_W-1:0]          r_rem;
    logic [QUO_W:0]            r_quo;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DELTA_W:0]   r_imm;
    logic signed [DELTA_W-1:0] r_out;

    logic [DELTA_W-1:0]        mag;
    logic [THR_W-2:0]          lo_thr;
    logic [THR_W-1:0]          den;
    logic signed [DELTA_W:0]   num;
    logic [AW-1:0]             nptr;
    logic [THR_W:0]            rem2;
    logic signed [PROD_W-1:0]  neg_prod;
    logic signed [DELTA_W:0]   sample_w;
    logic signed [DELTA_W-1:0] sample;
    logic signed [DELTA_W-1:0] old;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   avg;
    logic signed [RES_W-1:0]   res;
    logic signed [DELTA_W-1:0] n_out;

    always_comb begin
        mag    = i_delta_angle[DELTA_W-1] ? DELTA_W'(-i_delta_angle)
                                          : DELTA_W'(i_delta_angle);
        lo_thr = r_thr[THR_W-1:1];
        den    = {1'b0, lo_thr} + {{(THR_W-1){1'b0}}, r_thr[0]};
        num    = signed'({1'b0, mag}) - signed'({3'b000, lo_thr});
        nptr   = (r_ptr == LAST_IDX) ? '0 : AW'(r_ptr + 1'b1);
    end

    // restoring divide step: remainder stays below the divisor
    assign rem2 = {r_rem, 1'b0};

    always_comb begin
        neg_prod = -r_prod;
        sample_w = {r_v[DELTA_W-1], r_v} + neg_prod[DELTA_W+16:16];
        sample   = sample_w[DELTA_W-1:0];
        old      = r_valid[r_nptr] ? r_old : '0;
        n_sum    = r_sum - SUM_W'(old) + SUM_W'(sample);
        avg      = r_sum >>> LOG_D;
        res      = RES_W'(avg) + RES_W'(r_imm);
        priority if (r_clr) begin
            n_out = '0;
        end else if (r_byp) begin
            n_out = r_v;
        end else if (res < OUT_MIN) begin
            n_out = OUT_MIN[DELTA_W-1:0];
        end else if (res > OUT_MAX) begin
            n_out = OUT_MAX[DELTA_W-1:0];
        end else begin
            n_out = res[DELTA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_mem[r_nptr] <= sample;
        end
        r_old <= r_mem[nptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_ptr       <= '0;
            r_sum       <= '0;
            r_valid     <= '0;
            r_need      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_top_threshold;
            end
            if (i_cmd.load) begin
                r_cnt  <= '0;
                r_need <= !i_clear_history && (r_thr != '0) && !num[DELTA_W]
                          && (num != '0) && (num < signed'({2'b00, den}));
            end
            if (i_cmd.div_step) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_need <= 1'b0;
                end
            end
            if (i_cmd.acc) begin
                r_ptr            <= r_nptr;
                r_sum            <= n_sum;
                r_valid[r_nptr]  <= 1'b1;
            end
            if (i_cmd.out_load && r_clr) begin
                r_ptr   <= '0;
                r_sum   <= '0;
                r_valid <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v   <= i_delta_angle;
            r_clr <= i_clear_history;
            r_byp <= (r_thr == '0);
            r_den <= den;
            r_nptr <= nptr;
            r_rem <= num[THR_W-1:0];
            // weight saturates once the excess reaches the divisor
            if (num[DELTA_W] || num == '0) begin
                r_quo <= '0;
            end else if (num >= signed'({2'b00, den})) begin
                r_quo <= {1'b1, {QUO_W{1'b0}}};
            end else begin
                r_quo <= '0;
            end
        end
        if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= THR_W'(rem2 - {1'b0, r_den});
                r_quo <= {r_quo[QUO_W-1:0], 1'b1};
            end else begin
                r_rem <= rem2[THR_W-1:0];
                r_quo <= {r_quo[QUO_W-1:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_v) * PROD_W'(signed'({1'b0, r_quo}));
        end
        if (i_cmd.acc) begin
            r_imm <= r_prod[DELTA_W+16:16];
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.skip     = r_clr || r_byp;
    assign o_stat.need_div = r_need;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_smoothed_delta = r_out;

endmodule

// ===== hdl/soft_tiered_rotation_smoother_top.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_delta_angle, i_clear_history
// out       output     o_out_valid / i_out_stall o_smoothed_delta
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_top_threshold
//
// before the next input slot frees, an item whose weight needs the 16-step
// restoring divider runs the divide, multiply and accumulate steps; a weight
// of 0 or full skips the divide; a clear or zero threshold skips all three.
// a finished result sits in the output register while the next item is taken.
// reset is synchronous and active low: it empties the ring and loads the
// threshold with 2048. an output stall holds the item in its last step.
module soft_tiered_rotation_smoother_top #(
    parameter int HISTORY_DEPTH = strs_pkg::HIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [strs_pkg::DELTA_W-1:0] i_delta_angle,
    input  logic                                i_clear_history,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [strs_pkg::DELTA_W-1:0] o_smoothed_delta,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [strs_pkg::THR_W-1:0]   i_cfg_top_threshold
);
    import strs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    strs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    strs_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_delta_angle       (i_delta_angle),
        .i_clear_history     (i_clear_history),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_top_threshold (i_cfg_top_threshold),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_smoothed_delta    (o_smoothed_delta),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat)
    );

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken but block not busy");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.div_step, w_cmd.mul, w_cmd.acc, w_cmd.out_load}))
        else $error("more than one datapath command");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (o_out_valid && !o_in_stall))
        else $error("result not presented after completion");

endmodule
